/* sv/assert_macros.svh */
// Assertion macros shared by the PWM generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check a consequence in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mcpwm_pkg.sv */
// Shared constants, codes and types of the multi-channel PWM generator.
package mcpwm_pkg;

    localparam int CHANNELS         = 8;
    localparam int TICKS_PER_SECOND = 1000000;

    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHIN_W     = 4;
    localparam int OP_W       = 2;
    localparam int TICK_W     = 20;
    localparam int STEP_W     = 16;
    localparam int PIN_W      = 8;
    localparam int STAT_W     = 3;
    localparam int DIV_W      = TICK_W;
    localparam int PROD_W     = STEP_W + DIV_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_RANGE = 2'd2;
    localparam logic [OP_W-1:0] OP_DUTY  = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_CHANNEL = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_FREQ    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_RANGE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_FREQ_UNSET  = 3'd4;
    localparam logic [STAT_W-1:0] ST_BAD_VALUE   = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEPS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS = 3'd3;

    // Configuration reset values
    localparam logic [TICK_W-1:0] MIN_FREQ_RST  = 20'd1;
    localparam logic [TICK_W-1:0] MAX_FREQ_RST  = 20'd1000000;
    localparam logic [STEP_W-1:0] MIN_STEPS_RST = 16'd1;
    localparam logic [STEP_W-1:0] MAX_STEPS_RST = 16'd65535;

    // Per-channel state entry held in the channel memory
    typedef struct packed {
        logic [TICK_W-1:0] period;
        logic [STEP_W-1:0] range;
        logic [TICK_W-1:0] duty;
        logic [TICK_W-1:0] pending;
        logic [TICK_W-1:0] phase;
        logic              active;
    } chan_entry_t;

    localparam int ENTRY_W = $bits(chan_entry_t);

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

/* sv/mcpwm_ram.sv */
// Simple dual-port RAM with registered read.
module mcpwm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/mcpwm_div.sv */
// Restoring divider, one quotient bit per cycle.
module mcpwm_div (
    input  logic                clk,
    input  logic                rst_n,
    input  mcpwm_pkg::div_req_t req,
    output mcpwm_pkg::div_rsp_t rsp
);

    localparam int CNT_W = (mcpwm_pkg::DIV_W > 1) ? $clog2(mcpwm_pkg::DIV_W) : 1;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [mcpwm_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [mcpwm_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [mcpwm_pkg::DIV_W-1:0] dvs_reg, dvs_next;
    logic [mcpwm_pkg::DIV_W:0]   rem_shift;
    logic [mcpwm_pkg::DIV_W:0]   diff;
    logic                        fits;

    // Trial subtract of one step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[mcpwm_pkg::DIV_W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});
    end

    // Load on start, shift one bit per cycle, flag the last step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[mcpwm_pkg::DIV_W-2:0], fits};
            rem_next = fits ? diff[mcpwm_pkg::DIV_W-1:0] : rem_shift[mcpwm_pkg::DIV_W-1:0];
            if (cnt_reg == CNT_W'(mcpwm_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* sv/multi_channel_pwm_generator.sv */
// Top level of the multi-channel PWM generator: sequencer over the channel memory.
//
// Usage: each request on the input channel (in_valid/in_stall) is a tick or a
// write of one channel's frequency, range or duty value. Every request gives
// exactly one result (pin_mask, status) on the output channel (out_valid/out_stall).
// Limit registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high and writes are meant for idle periods only.
// Per-channel state lives in one RAM read and written back by the sequencer.
// From accept to result: a tick visits the channel entries in order, one channel
// entry per cycle through the RAM port; a valid frequency write runs one division
// and a duty write up to two divisions on the bit-serial divider; a range write
// passes the load, evaluate and write-back states. One request is in work at a time.
// A new request is taken while the previous result still waits in the output
// register; if out_stall holds, the finished result waits in the sequencer.
// Reset clears the limits to their defaults, all channels to unset and the pin
// levels to zero; channel entries read as zero until first written.
module multi_channel_pwm_generator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mcpwm_pkg::OP_W-1:0]         operation,
    input  logic [mcpwm_pkg::CHIN_W-1:0]       channel,
    input  logic [mcpwm_pkg::TICK_W-1:0]       frequency,
    input  logic [mcpwm_pkg::STEP_W-1:0]       steps,
    input  logic [mcpwm_pkg::STEP_W-1:0]       duty_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mcpwm_pkg::PIN_W-1:0]        pin_mask,
    output logic [mcpwm_pkg::STAT_W-1:0]       status,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mcpwm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcpwm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    `include "assert_macros.svh"

    localparam int CH_W   = mcpwm_pkg::CH_W;
    localparam int TICK_W = mcpwm_pkg::TICK_W;
    localparam int STEP_W = mcpwm_pkg::STEP_W;
    localparam int PIN_W  = mcpwm_pkg::PIN_W;
    localparam int DIV_W  = mcpwm_pkg::DIV_W;
    localparam int PROD_W = mcpwm_pkg::PROD_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TICK = 4'd1;
    localparam logic [3:0] S_LOAD = 4'd2;
    localparam logic [3:0] S_EVAL = 4'd3;
    localparam logic [3:0] S_DIVF = 4'd4;
    localparam logic [3:0] S_DIVQ = 4'd5;
    localparam logic [3:0] S_DIVD = 4'd6;
    localparam logic [3:0] S_SAT  = 4'd7;
    localparam logic [3:0] S_WB   = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]                        state_reg, state_next;
    logic [mcpwm_pkg::OP_W-1:0]        op_reg, op_next;
    logic [mcpwm_pkg::CHIN_W-1:0]      ch_reg, ch_next;
    logic [TICK_W-1:0]                 freq_reg, freq_next;
    logic [STEP_W-1:0]                 steps_reg, steps_next;
    logic [STEP_W-1:0]                 val_reg, val_next;
    mcpwm_pkg::chan_entry_t            entry_reg, entry_next;
    logic [PROD_W-1:0]                 prod_reg, prod_next;
    logic [mcpwm_pkg::STAT_W-1:0]      status_reg, status_next;
    logic [CH_W:0]                     rd_idx_reg, rd_idx_next;
    logic [CH_W-1:0]                   proc_idx_reg, proc_idx_next;
    logic [PIN_W-1:0]                  mask_reg, mask_next;
    logic [PIN_W-1:0]                  pin_levels_reg, pin_levels_next;
    logic                              out_valid_reg, out_valid_next;
    logic [PIN_W-1:0]                  out_pin_reg, out_pin_next;
    logic [mcpwm_pkg::STAT_W-1:0]      out_status_reg, out_status_next;
    logic [mcpwm_pkg::CHANNELS-1:0]    valid_bits_reg, valid_bits_next;
    logic                              rd_valid_reg, rd_valid_next;
    logic [TICK_W-1:0]                 min_freq_reg, min_freq_next;
    logic [TICK_W-1:0]                 max_freq_reg, max_freq_next;
    logic [STEP_W-1:0]                 min_steps_reg, min_steps_next;
    logic [STEP_W-1:0]                 max_steps_reg, max_steps_next;

    logic                              in_accept;
    logic                              bad_channel;
    logic                              out_load;
    logic                              ram_wr_en;
    logic [CH_W-1:0]                   ram_wr_addr;
    mcpwm_pkg::chan_entry_t            ram_wr_data;
    logic                              ram_rd_en;
    logic [CH_W-1:0]                   ram_rd_addr;
    logic [mcpwm_pkg::ENTRY_W-1:0]     ram_rd_data;
    mcpwm_pkg::chan_entry_t            rd_entry;
    mcpwm_pkg::chan_entry_t            tick_entry;
    logic                              tick_run;
    logic                              tick_level;
    logic [TICK_W-1:0]                 duty_eff;
    logic [TICK_W:0]                   phase_inc;
    logic                              range_big;
    logic [PROD_W-1:0]                 mul_res;
    mcpwm_pkg::div_req_t               div_req;
    mcpwm_pkg::div_rsp_t               div_rsp;

    // Channel state memory
    mcpwm_ram #(
        .WIDTH (mcpwm_pkg::ENTRY_W),
        .DEPTH (mcpwm_pkg::CHANNELS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Shared divider
    mcpwm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign bad_channel = ({1'b0, channel} >= (mcpwm_pkg::CHIN_W + 1)'(mcpwm_pkg::CHANNELS));
    assign cfg_ready   = 1'b1;

    // Entries never written read as zero
    assign rd_entry = rd_valid_reg ? mcpwm_pkg::chan_entry_t'(ram_rd_data)
                                   : mcpwm_pkg::chan_entry_t'('0);

    // Advance one channel by one tick
    always_comb
    begin
        tick_entry = rd_entry;
        tick_run   = rd_entry.active && (rd_entry.period != '0);
        duty_eff   = (rd_entry.phase == '0) ? rd_entry.pending : rd_entry.duty;
        tick_level = tick_run && (rd_entry.phase < duty_eff);
        phase_inc  = {1'b0, rd_entry.phase} + 1'b1;
        if (tick_run)
        begin
            tick_entry.duty  = duty_eff;
            tick_entry.phase = (phase_inc >= {1'b0, rd_entry.period})
                               ? '0 : phase_inc[TICK_W-1:0];
        end
    end

    assign range_big = (DIV_W'(entry_reg.range) > entry_reg.period);
    assign mul_res   = val_reg * div_rsp.quotient;

    // Request sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        ch_next         = ch_reg;
        freq_next       = freq_reg;
        steps_next      = steps_reg;
        val_next        = val_reg;
        entry_next      = entry_reg;
        prod_next       = prod_reg;
        status_next     = status_reg;
        rd_idx_next     = rd_idx_reg;
        proc_idx_next   = proc_idx_reg;
        mask_next       = mask_reg;
        pin_levels_next = pin_levels_reg;
        valid_bits_next = valid_bits_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = ch_reg[CH_W-1:0];
        ram_wr_en       = 1'b0;
        ram_wr_addr     = ch_reg[CH_W-1:0];
        ram_wr_data     = entry_reg;
        div_req         = '0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next     = operation;
                    ch_next     = channel;
                    freq_next   = frequency;
                    steps_next  = steps;
                    val_next    = duty_value;
                    status_next = mcpwm_pkg::ST_OK;
                    if (operation == mcpwm_pkg::OP_TICK)
                    begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = '0;
                        rd_idx_next   = (CH_W + 1)'(1);
                        proc_idx_next = '0;
                        mask_next     = '0;
                        state_next    = S_TICK;
                    end
                    else if (bad_channel)
                    begin
                        status_next = mcpwm_pkg::ST_BAD_CHANNEL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = channel[CH_W-1:0];
                        state_next  = S_LOAD;
                    end
                end
            end

            S_TICK:
            begin
                // Write back the channel read last cycle, read the next one
                ram_wr_en   = 1'b1;
                ram_wr_addr = proc_idx_reg;
                ram_wr_data = tick_entry;
                valid_bits_next[proc_idx_reg] = 1'b1;
                mask_next   = mask_reg | (PIN_W'(tick_level) << proc_idx_reg);
                if (rd_idx_reg < (CH_W + 1)'(mcpwm_pkg::CHANNELS))
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rd_idx_reg[CH_W-1:0];
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (proc_idx_reg == CH_W'(mcpwm_pkg::CHANNELS - 1))
                begin
                    pin_levels_next = mask_next;
                    state_next      = S_DONE;
                end
                else
                begin
                    proc_idx_next = proc_idx_reg + 1'b1;
                end
            end

            S_LOAD:
            begin
                entry_next = rd_entry;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                unique case (op_reg)
                    mcpwm_pkg::OP_FREQ:
                    begin
                        if ((freq_reg == '0) || (freq_reg < min_freq_reg)
                            || (freq_reg > max_freq_reg))
                        begin
                            status_next = mcpwm_pkg::ST_BAD_FREQ;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = DIV_W'(mcpwm_pkg::TICKS_PER_SECOND);
                            div_req.divisor  = freq_reg;
                            state_next       = S_DIVF;
                        end
                    end
                    mcpwm_pkg::OP_RANGE:
                    begin
                        if ((steps_reg == '0) || (steps_reg < min_steps_reg)
                            || (steps_reg > max_steps_reg))
                        begin
                            status_next = mcpwm_pkg::ST_BAD_RANGE;
                            state_next  = S_DONE;
                        end
                        else if (entry_reg.period == '0)
                        begin
                            status_next = mcpwm_pkg::ST_FREQ_UNSET;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            entry_next.range   = steps_reg;
                            entry_next.pending = '0;
                            entry_next.active  = 1'b1;
                            state_next         = S_WB;
                        end
                    end
                    default:
                    begin
                        // Duty value write
                        if (val_reg > entry_reg.range)
                        begin
                            status_next = mcpwm_pkg::ST_BAD_VALUE;
                            state_next  = S_DONE;
                        end
                        else if ((entry_reg.range == '0) || (entry_reg.period == '0))
                        begin
                            entry_next.pending = '0;
                            state_next         = S_WB;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            if (range_big)
                            begin
                                div_req.dividend = DIV_W'(entry_reg.range);
                                div_req.divisor  = entry_reg.period;
                            end
                            else
                            begin
                                div_req.dividend = entry_reg.period;
                                div_req.divisor  = DIV_W'(entry_reg.range);
                            end
                            state_next = S_DIVQ;
                        end
                    end
                endcase
            end

            S_DIVF:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder != '0)
                    begin
                        status_next = mcpwm_pkg::ST_BAD_FREQ;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        entry_next.period  = div_rsp.quotient;
                        entry_next.pending = '0;
                        entry_next.phase   = '0;
                        state_next         = S_WB;
                    end
                end
            end

            S_DIVQ:
            begin
                // Steps per tick or ticks per step is ready
                if (div_rsp.done)
                begin
                    if (range_big)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(val_reg);
                        div_req.divisor  = div_rsp.quotient;
                        state_next       = S_DIVD;
                    end
                    else
                    begin
                        prod_next  = mul_res;
                        state_next = S_SAT;
                    end
                end
            end

            S_DIVD:
            begin
                if (div_rsp.done)
                begin
                    prod_next  = PROD_W'(div_rsp.quotient);
                    state_next = S_SAT;
                end
            end

            S_SAT:
            begin
                entry_next.pending = (prod_reg > PROD_W'(entry_reg.period))
                                     ? entry_reg.period : prod_reg[TICK_W-1:0];
                state_next         = S_WB;
            end

            S_WB:
            begin
                ram_wr_en = 1'b1;
                valid_bits_next[ch_reg[CH_W-1:0]] = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hold the result until the output register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Track whether the entry being read was ever written
    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        if (ram_rd_en)
        begin
            rd_valid_next = valid_bits_reg[ram_rd_addr];
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        out_pin_next    = out_pin_reg;
        out_status_next = out_status_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_pin_next    = pin_levels_reg;
            out_status_next = status_reg;
        end
    end

    // Configuration writes
    always_comb
    begin
        min_freq_next  = min_freq_reg;
        max_freq_next  = max_freq_reg;
        min_steps_next = min_steps_reg;
        max_steps_next = max_steps_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mcpwm_pkg::CFG_MIN_FREQ:  min_freq_next  = cfg_data[TICK_W-1:0];
                mcpwm_pkg::CFG_MAX_FREQ:  max_freq_next  = cfg_data[TICK_W-1:0];
                mcpwm_pkg::CFG_MIN_STEPS: min_steps_next = cfg_data[STEP_W-1:0];
                mcpwm_pkg::CFG_MAX_STEPS: max_steps_next = cfg_data[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_idx_reg     <= '0;
            proc_idx_reg   <= '0;
            pin_levels_reg <= '0;
            out_valid_reg  <= 1'b0;
            valid_bits_reg <= '0;
            rd_valid_reg   <= 1'b0;
            min_freq_reg   <= mcpwm_pkg::MIN_FREQ_RST;
            max_freq_reg   <= mcpwm_pkg::MAX_FREQ_RST;
            min_steps_reg  <= mcpwm_pkg::MIN_STEPS_RST;
            max_steps_reg  <= mcpwm_pkg::MAX_STEPS_RST;
        end
        else
        begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            proc_idx_reg   <= proc_idx_next;
            pin_levels_reg <= pin_levels_next;
            out_valid_reg  <= out_valid_next;
            valid_bits_reg <= valid_bits_next;
            rd_valid_reg   <= rd_valid_next;
            min_freq_reg   <= min_freq_next;
            max_freq_reg   <= max_freq_next;
            min_steps_reg  <= min_steps_next;
            max_steps_reg  <= max_steps_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        ch_reg         <= ch_next;
        freq_reg       <= freq_next;
        steps_reg      <= steps_next;
        val_reg        <= val_next;
        entry_reg      <= entry_next;
        prod_reg       <= prod_next;
        status_reg     <= status_next;
        mask_reg       <= mask_next;
        out_pin_reg    <= out_pin_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid = out_valid_reg;
    assign pin_mask  = out_pin_reg;
    assign status    = out_status_reg;

    // Checks on the sequencer and datapath
    `ASSERT_IMPLY(a_ram_no_clash, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr, "RAM read and write hit the same entry")
    `ASSERT_IMPLY(a_div_start_idle, div_req.start, !div_rsp.busy, "divider started while busy")
    `ASSERT_IMPLY(a_duty_sat, ram_wr_en, ram_wr_data.pending <= ram_wr_data.period, "pending duty exceeds period")
    `ASSERT_NEXT(a_tick_ok, out_load && (op_reg == mcpwm_pkg::OP_TICK), status == mcpwm_pkg::ST_OK, "tick result without ok status")

endmodule
